[hdl/tem_pkg.sv]
// tem_pkg: shared constants and types for the threshold event merger.
// No dependencies; imported by every module of the block.
`default_nettype none

package tem_pkg;

    // Configuration port geometry
    localparam int DATA_BITS = 32;
    localparam int ADDR_BITS = 3;

    // Reset level of the threshold register (6.0 in Q8.8)
    localparam int THRESHOLD_RESET = 1536;

    // Queue depths (powers of two)
    localparam int CQ_DEPTH = 4;
    localparam int RQ_DEPTH = 4;

    // Register select, taken from paddr[2]
    typedef enum logic {
        REG_THRESHOLD      = 1'b0,
        REG_MERGE_DISTANCE = 1'b1
    } reg_sel_t;

    // Per-sample classification carried with each command
    typedef struct packed {
        logic above;
        logic last;
    } cmd_flags_t;

    // Queue status seen by producer and consumer
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

`default_nettype wire

[hdl/tem_cmdq.sv]
// tem_cmdq: small register FIFO between front and back sections.
// Depends on tem_pkg (q_status_t).
`default_nettype none

module tem_cmdq #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 4
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic [WIDTH-1:0]   wdata,
    input  wire logic               pop,
    output logic [WIDTH-1:0]        rdata,
    output tem_pkg::q_status_t      status
);
    import tem_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == CNT_W'(DEPTH));
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = mem_reg[rp_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wp_reg <= wp_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[hdl/tem_front.sv]
// tem_front: numbers incoming samples and compares them against the threshold.
// Depends on tem_pkg; feeds tem_cmdq.
`default_nettype none

module tem_front #(
    parameter int INDEX_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [SAMPLE_BITS-1:0]         sample_value,
    input  wire logic                                  last_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]         threshold,
    input  wire tem_pkg::q_status_t                    cq_status,
    output logic                                       cq_push,
    output logic [2+SAMPLE_BITS+INDEX_BITS-1:0]        cq_data
);
    import tem_pkg::*;

    logic [INDEX_BITS-1:0] idx_reg;
    logic [INDEX_BITS-1:0] idx_next;
    cmd_flags_t            flags;

    assign full    = cq_status.full;
    assign cq_push = push && !cq_status.full;

    // classify the sample
    always_comb
    begin
        flags.above = (sample_value > threshold);
        flags.last  = last_sample;
        cq_data     = {flags, sample_value, idx_reg};
    end

    // sample index restarts after the final sample of a series
    always_comb
    begin
        idx_next = last_sample ? '0 : idx_reg + INDEX_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cq_push)
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

`default_nettype wire

[hdl/tem_back.sv]
// tem_back: event tracking and merging, plus the result queue (up to two writes per cycle).
// Depends on tem_pkg; consumes commands from tem_cmdq.
`default_nettype none

module tem_back #(
    parameter int INDEX_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic [INDEX_BITS-1:0]              merge_distance,
    input  wire tem_pkg::q_status_t                 cq_status,
    input  wire logic [2+SAMPLE_BITS+INDEX_BITS-1:0] cq_data,
    output logic                                    cq_pop,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [SAMPLE_BITS-1:0]           peak_value,
    output logic [INDEX_BITS-1:0]                   peak_index,
    output logic [INDEX_BITS-1:0]                   begin_index,
    output logic [INDEX_BITS:0]                     end_index,
    output logic                                    last_event
);
    import tem_pkg::*;

    localparam int REC_W = SAMPLE_BITS + 3 * INDEX_BITS + 2;
    localparam int PTR_W = $clog2(RQ_DEPTH);
    localparam int CNT_W = $clog2(RQ_DEPTH + 1);

    // command fields
    cmd_flags_t                   c_flags;
    logic signed [SAMPLE_BITS-1:0] c_value;
    logic [INDEX_BITS-1:0]        c_idx;

    // open event state
    logic                          open_reg;
    logic [INDEX_BITS-1:0]         begin_reg;
    logic [INDEX_BITS-1:0]         lastab_reg;
    logic signed [SAMPLE_BITS-1:0] pval_reg;
    logic [INDEX_BITS-1:0]         pidx_reg;
    logic                          open_next;
    logic [INDEX_BITS-1:0]         begin_next;
    logic [INDEX_BITS-1:0]         lastab_next;
    logic signed [SAMPLE_BITS-1:0] pval_next;
    logic [INDEX_BITS-1:0]         pidx_next;

    logic [INDEX_BITS:0]           gap_limit;
    logic                          is_gap;
    logic                          close_ev;
    logic                          final_ev;
    logic                          fire;
    logic [REC_W-1:0]              closed_rec;
    logic [REC_W-1:0]              final_rec;
    logic [REC_W-1:0]              slot0_rec;
    logic [1:0]                    wcnt;

    // result queue
    logic [REC_W-1:0] mem_reg [RQ_DEPTH];
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             pop_ok;
    logic [REC_W-1:0] head_rec;

    assign {c_flags, c_value, c_idx} = cq_data;

    // take a command only when the result queue can absorb two events
    assign fire   = !cq_status.empty && (cnt_reg <= CNT_W'(RQ_DEPTH - 2));
    assign cq_pop = fire;

    // gap test without overflow on the stored index
    always_comb
    begin
        gap_limit = {1'b0, lastab_reg} + {1'b0, merge_distance};
        is_gap    = ({1'b0, c_idx} > gap_limit);
    end

    // state update for one sample
    always_comb
    begin
        open_next   = open_reg;
        begin_next  = begin_reg;
        lastab_next = lastab_reg;
        pval_next   = pval_reg;
        pidx_next   = pidx_reg;
        close_ev    = 1'b0;
        if (c_flags.above)
        begin
            if (!open_reg || is_gap)
            begin
                close_ev    = open_reg;
                open_next   = 1'b1;
                begin_next  = c_idx;
                lastab_next = c_idx;
                pval_next   = c_value;
                pidx_next   = c_idx;
            end
            else
            begin
                lastab_next = c_idx;
                if (c_value > pval_reg)
                begin
                    pval_next = c_value;
                    pidx_next = c_idx;
                end
            end
        end
        final_ev = c_flags.last && open_next;
    end

    // event records
    always_comb
    begin
        closed_rec = {pval_reg, pidx_reg, begin_reg,
                      {1'b0, lastab_reg} + (INDEX_BITS + 1)'(1), 1'b0};
        final_rec  = {pval_next, pidx_next, begin_next,
                      {1'b0, lastab_next} + (INDEX_BITS + 1)'(1), 1'b1};
        slot0_rec  = close_ev ? closed_rec : final_rec;
        wcnt       = fire ? (2'(close_ev) + 2'(final_ev)) : 2'd0;
    end

    // open-event flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (fire)
        begin
            open_reg <= open_next && !c_flags.last;
        end
    end

    // open-event payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            begin_reg  <= begin_next;
            lastab_reg <= lastab_next;
            pval_reg   <= pval_next;
            pidx_reg   <= pidx_next;
        end
    end

    // result queue control
    assign empty  = (cnt_reg == '0);
    assign pop_ok = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PTR_W'(wcnt);
            rp_reg  <= rp_reg + PTR_W'(pop_ok);
            cnt_reg <= cnt_reg + CNT_W'(wcnt) - CNT_W'(pop_ok);
        end
    end

    // result queue storage, up to two transfers written per cycle
    always_ff @(posedge clk)
    begin
        if (wcnt != 2'd0)
        begin
            mem_reg[wp_reg] <= slot0_rec;
        end
        if (wcnt == 2'd2)
        begin
            mem_reg[wp_reg + PTR_W'(1)] <= final_rec;
        end
    end

    // head of the queue
    assign head_rec = mem_reg[rp_reg];
    assign {peak_value, peak_index, begin_index, end_index, last_event} = head_rec;

endmodule

`default_nettype wire

[hdl/threshold_event_merger.sv]
// threshold_event_merger: top level; configuration registers and the front/back sections.
// Depends on tem_pkg, tem_front, tem_cmdq, tem_back.
//
//   Channel   Handshake                      Payload
//   input     push / full                    sample_value, last_sample
//   result    empty / pop                    peak_value, peak_index, begin_index,
//                                            end_index, last_event
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One sample per cycle is taken while full is low; the event unit handles one command
// per cycle while the result queue has room for two results. A sample's command is
// registered in the command queue; the event unit writes its results into the result
// queue, whose head drives the result ports. A sample that closes one event and
// flushes another writes two results in the same cycle. Reset clears the index
// counter, open-event flag and queues; registers return to threshold 1536, merge
// distance 0. A stalled result side backs up into the command queue, which raises full.
`default_nettype none

module threshold_event_merger #(
    parameter int INDEX_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // sample input
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample_value,
    input  wire logic                                last_sample,
    // event output
    output logic                                     empty,
    input  wire logic                                pop,
    output logic signed [SAMPLE_BITS-1:0]            peak_value,
    output logic [INDEX_BITS-1:0]                    peak_index,
    output logic [INDEX_BITS-1:0]                    begin_index,
    output logic [INDEX_BITS:0]                      end_index,
    output logic                                     last_event,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tem_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [tem_pkg::DATA_BITS-1:0]       pwdata,
    output logic [tem_pkg::DATA_BITS-1:0]            prdata,
    output logic                                     pready
);
    import tem_pkg::*;

    localparam int CMD_W = 2 + SAMPLE_BITS + INDEX_BITS;

    logic signed [SAMPLE_BITS-1:0] threshold_reg;
    logic [INDEX_BITS-1:0]         merge_reg;
    logic                          cfg_wr;
    reg_sel_t                      cfg_sel;

    logic             cq_push;
    logic             cq_pop;
    logic [CMD_W-1:0] cq_wdata;
    logic [CMD_W-1:0] cq_rdata;
    q_status_t        cq_status;

    // configuration access
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= SAMPLE_BITS'(THRESHOLD_RESET);
            merge_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                REG_THRESHOLD:      threshold_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_MERGE_DISTANCE: merge_reg     <= pwdata[INDEX_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // register read-back
    always_comb
    begin
        unique case (cfg_sel)
            REG_THRESHOLD:      prdata = DATA_BITS'(threshold_reg);
            REG_MERGE_DISTANCE: prdata = DATA_BITS'(merge_reg);
            default:            prdata = '0;
        endcase
    end

    tem_front #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .sample_value (sample_value),
        .last_sample  (last_sample),
        .threshold    (threshold_reg),
        .cq_status    (cq_status),
        .cq_push      (cq_push),
        .cq_data      (cq_wdata)
    );

    tem_cmdq #(
        .WIDTH (CMD_W),
        .DEPTH (CQ_DEPTH)
    ) u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (cq_push),
        .wdata  (cq_wdata),
        .pop    (cq_pop),
        .rdata  (cq_rdata),
        .status (cq_status)
    );

    tem_back #(
        .INDEX_BITS  (INDEX_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .merge_distance (merge_reg),
        .cq_status      (cq_status),
        .cq_data        (cq_rdata),
        .cq_pop         (cq_pop),
        .empty          (empty),
        .pop            (pop),
        .peak_value     (peak_value),
        .peak_index     (peak_index),
        .begin_index    (begin_index),
        .end_index      (end_index),
        .last_event     (last_event)
    );

endmodule

`default_nettype wire

[hdl/tem_checker.sv]
// tem_checker: port-level checks of the threshold event merger, bound to the top level.
// Depends on tem_pkg and threshold_event_merger.
`default_nettype none

module tem_checker #(
    parameter int INDEX_BITS  = 24,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                empty,
    input  wire logic                                pop,
    input  wire logic signed [SAMPLE_BITS-1:0]       peak_value,
    input  wire logic [INDEX_BITS-1:0]               peak_index,
    input  wire logic [INDEX_BITS-1:0]               begin_index,
    input  wire logic [INDEX_BITS:0]                 end_index,
    input  wire logic                                last_event,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tem_pkg::ADDR_BITS-1:0]       paddr,
    input  wire logic [tem_pkg::DATA_BITS-1:0]       pwdata,
    input  wire logic [tem_pkg::DATA_BITS-1:0]       prdata,
    input  wire logic                                pready
);
    import tem_pkg::*;

    // nothing waits on the result side right after reset
    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
    else $error("result queue not empty after reset");

    // a waiting result holds until its transfer
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(peak_value) && $stable(peak_index)
                              && $stable(begin_index) && $stable(end_index)
                              && $stable(last_event)))
    else $error("waiting result changed before its transfer");

    // exclusive end index is always at least one
    a_end_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (end_index != '0))
    else $error("result with zero end index");

    // merge distance reads back what was just written
    a_merge_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && !pwrite && paddr[2]
         && $past(psel && penable && pwrite && pready && paddr[2]))
        |-> (prdata[INDEX_BITS-1:0] == $past(pwdata[INDEX_BITS-1:0])))
    else $error("merge distance read-back mismatch");

endmodule

bind threshold_event_merger tem_checker #(
    .INDEX_BITS  (INDEX_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_tem_checker (.*);

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for threshold_event_merger, with scoreboard class and drivers.
// Depends on tem_pkg and the threshold_event_merger RTL; reads no files.

module tb;
    import tem_pkg::*;

    localparam int IDX_W         = 24;
    localparam int SMP_W         = 16;
    localparam int CLK_PERIOD    = 20;
    localparam int SETTLE_CYCLES = 12;       // generous padding after the last predicted event
    localparam int LIMIT_NS      = 8_000_000;

    typedef logic signed [SMP_W-1:0] sample_t;

    typedef struct packed {
        logic signed [SMP_W-1:0] peak_value;
        logic [IDX_W-1:0]        peak_index;
        logic [IDX_W-1:0]        begin_index;
        logic [IDX_W:0]          end_index;
        logic                    last_event;
    } event_t;

    // Mirrors the event detector and holds the events it predicts, oldest first
    class event_scoreboard;
        sample_t          threshold;
        logic [IDX_W-1:0] merge_distance;
        logic [IDX_W-1:0] sample_idx;
        bit               in_event;
        logic [IDX_W-1:0] begin_idx;
        logic [IDX_W-1:0] last_above;
        sample_t          peak_val;
        logic [IDX_W-1:0] peak_idx;
        event_t           expected_events[$];
        int               samples_seen;
        int               events_checked;
        int               errors;

        function new();
            threshold      = sample_t'(THRESHOLD_RESET);
            merge_distance = '0;
            sample_idx     = '0;
            in_event       = 1'b0;
            begin_idx      = '0;
            last_above     = '0;
            peak_val       = '0;
            peak_idx       = '0;
            samples_seen   = 0;
            events_checked = 0;
            errors         = 0;
        endfunction

        function event_t open_event(bit is_last);
            event_t e;
            e.peak_value  = peak_val;
            e.peak_index  = peak_idx;
            e.begin_index = begin_idx;
            e.end_index   = {1'b0, last_above} + 1'b1;
            e.last_event  = is_last;
            return e;
        endfunction

        // Accepted sample: advance the detector, queue any events it closes
        function void note_sample(sample_t v, logic is_last);
            logic [IDX_W-1:0] idx;
            idx = sample_idx;
            samples_seen++;
            if (v > threshold) begin
                // gap test on wide integers so a large merge distance cannot wrap
                if (!in_event ||
                    longint'(idx) > longint'(last_above) + longint'(merge_distance)) begin
                    if (in_event)
                        expected_events.push_back(open_event(1'b0));
                    in_event   = 1'b1;
                    begin_idx  = idx;
                    last_above = idx;
                    peak_val   = v;
                    peak_idx   = idx;
                end
                else begin
                    last_above = idx;
                    if (v > peak_val) begin
                        peak_val = v;
                        peak_idx = idx;
                    end
                end
            end
            // end of series: flush the open event, restart numbering
            if (is_last) begin
                if (in_event)
                    expected_events.push_back(open_event(1'b1));
                in_event   = 1'b0;
                sample_idx = '0;
            end
            else begin
                sample_idx = idx + 1'b1;
            end
        endfunction

        // Accepted event: compare with the oldest prediction
        function void check_event(event_t got);
            event_t want;
            if (expected_events.size() == 0) begin
                $error("unexpected event: peak_value %0d begin_index %0d end_index %0d",
                       got.peak_value, got.begin_index, got.end_index);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            events_checked++;
            if (got.peak_value !== want.peak_value) begin
                $error("peak_value: expected %0d, got %0d", want.peak_value, got.peak_value);
                errors++;
            end
            if (got.peak_index !== want.peak_index) begin
                $error("peak_index: expected %0d, got %0d", want.peak_index, got.peak_index);
                errors++;
            end
            if (got.begin_index !== want.begin_index) begin
                $error("begin_index: expected %0d, got %0d", want.begin_index, got.begin_index);
                errors++;
            end
            if (got.end_index !== want.end_index) begin
                $error("end_index: expected %0d, got %0d", want.end_index, got.end_index);
                errors++;
            end
            if (got.last_event !== want.last_event) begin
                $error("last_event: expected %0d, got %0d", want.last_event, got.last_event);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    sample_t                sample_value;
    logic                   last_sample;
    logic                   empty;
    logic                   pop;
    sample_t                peak_value;
    logic [IDX_W-1:0]       peak_index;
    logic [IDX_W-1:0]       begin_index;
    logic [IDX_W:0]         end_index;
    logic                   last_event;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [ADDR_BITS-1:0]   paddr;
    logic [DATA_BITS-1:0]   pwdata;
    logic [DATA_BITS-1:0]   prdata;
    logic                   pready;

    event_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int recv_hold      = 0;
    int random_sent    = 0;
    int settings_used  = 0;
    int full_stalls    = 0;

    threshold_event_merger DUT (
        .clk, .rst_n,
        .push, .full, .sample_value, .last_sample,
        .empty, .pop, .peak_value, .peak_index, .begin_index, .end_index, .last_event,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offer one sample, optionally after idle cycles; returns once it transfers
    task automatic send_sample(input sample_t v, input logic is_last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push         <= 1'b1;
        sample_value <= v;
        last_sample  <= is_last;
        do begin
            @(posedge clk);
            if (full)
                full_stalls++;
        end while (full);
        sb.note_sample(v, is_last);
    endtask

    // Wait until every predicted event has come out and the pipeline is empty
    task automatic settle();
        push <= 1'b0;
        while (sb.expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write followed by a read-back of the same register
    task automatic write_reg(input reg_sel_t sel, input logic [DATA_BITS-1:0] data);
        logic [DATA_BITS-1:0] mask;
        mask = (sel == REG_THRESHOLD) ? DATA_BITS'({SMP_W{1'b1}}) : DATA_BITS'({IDX_W{1'b1}});
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // back-to-back read transfer
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (((prdata ^ data) & mask) != '0) begin
            $error("prdata of %s: expected %0h, got %0h", sel.name(), data & mask,
                   prdata & mask);
            sb.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input sample_t thr, input logic [IDX_W-1:0] md);
        settle();
        write_reg(REG_THRESHOLD, {{(DATA_BITS - SMP_W){thr[SMP_W-1]}}, thr});
        write_reg(REG_MERGE_DISTANCE, DATA_BITS'(md));
        sb.threshold      = thr;
        sb.merge_distance = md;
        settings_used++;
    endtask

    // Values cluster around the threshold so events start, merge, tie and split
    function automatic sample_t pick_value(sample_t thr);
        case ($urandom_range(0, 3))
            0:       return sample_t'($urandom);
            1:       return sample_t'(int'(thr) + int'($urandom_range(0, 6)) - 3);
            2:       return sample_t'(int'(thr) + 1 + int'($urandom_range(0, 3)));
            default: return sample_t'(int'(thr) - 1 - int'($urandom_range(0, 200)));
        endcase
    endfunction

    // Random series under one register setting; idling pattern rotates every 100 samples
    task automatic run_phase(input sample_t thr, input logic [IDX_W-1:0] md, input int n_items);
        int left;
        bit is_last;
        configure(thr, md);
        left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (left == 0)
                left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                                    : $urandom_range(25, 300);
            is_last = (left == 1) || (i == n_items - 1);
            left--;
            case ((random_sent / 100) % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            send_sample(pick_value(thr), is_last);
            random_sent++;
        end
    endtask

    // Result side: check each transfer, then decide whether to pop next cycle
    initial begin
        event_t got;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (pop && !empty) begin
                got = '{peak_value, peak_index, begin_index, end_index, last_event};
                sb.check_event(got);
            end
            if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end
            else begin
                pop <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Stimulus
    initial begin
        sb           = new();
        rst_n        = 1'b0;
        push         = 1'b0;
        sample_value = '0;
        last_sample  = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // series with no event: zero, minimum, exactly at the threshold
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0600, 1'b1);
        // lone maximum that is also the final sample
        send_sample(16'sh7FFF, 1'b1);
        // tied peak keeps the earlier index; a gap closes the event; final flush
        send_sample(16'sh0601, 1'b0);
        send_sample(16'sh0640, 1'b0);
        send_sample(16'sh0640, 1'b0);
        send_sample(16'sh0064, 1'b0);
        send_sample(16'sh07D0, 1'b0);
        send_sample(16'sh8000, 1'b1);
        // final sample starts a new event: close and flush in one transfer
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0700, 1'b1);
        // merge distance 2: gap of two merges, gap of three splits
        configure(sample_t'(THRESHOLD_RESET), 24'd2);
        send_sample(16'sh0700, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0701, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'sh0800, 1'b0);
        send_sample(16'sh5555, 1'b1);

        // back-pressure: result side holds off while one-sample series keep coming
        configure(16'sh8000, 24'd0);
        recv_hold = 150;
        repeat (40) send_sample(sample_t'($urandom), 1'b1);

        run_phase(sample_t'(THRESHOLD_RESET), 24'd0, 300);
        run_phase(16'sh8000, 24'd0, 200);
        run_phase(16'sh7FFF, 24'hFFFFFF, 100);
        run_phase(16'sh0000, 24'hFFFFFF, 200);
        run_phase(-16'sd256, 24'd3, 400);
        run_phase(sample_t'($urandom), 24'($urandom_range(0, 7)), 400);

        settle();
        $display("Covered %0d samples (%0d random) under %0d register settings.",
                 sb.samples_seen, random_sent, settings_used);
        $display("Checked %0d events; input was held off for %0d cycles.",
                 sb.events_checked, full_stalls);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(LIMIT_NS);
        $display("tb failed");
        $finish;
    end

endmodule

[files.f]
hdl/tem_pkg.sv
hdl/tem_cmdq.sv
hdl/tem_front.sv
hdl/tem_back.sv
hdl/threshold_event_merger.sv
hdl/tem_checker.sv
tb/tb.sv
